// File: rtl/core/tds_pkg.sv
// shared types, constants and helpers for the tridiagonal solver
package tds_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int IDX_W     = $clog2(MAX_ROWS);
    localparam int PROD_W    = 2 * Q_W;
    localparam int DIFF_W    = PROD_W + 1;
    localparam int NUM_W     = Q_W + FRAC_BITS;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_RD,
        S_F_DIV,
        S_F_DIVW,
        S_F_MUL1,
        S_F_SUB1,
        S_F_MUL2,
        S_F_SUB2,
        S_F_END,
        S_B_RD,
        S_B_SEL,
        S_B_SUB,
        S_B_DIV,
        S_B_DIVW,
        S_B_OUT
    } t_state;

    typedef struct packed {
        logic                    ovf;
        logic signed [Q_W-1:0]   val;
    } t_sat;

    typedef struct packed {
        logic                    start;
        logic signed [Q_W-1:0]   num;
        logic signed [Q_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic                    err;
        logic signed [Q_W-1:0]   quo;
    } t_div_rsp;

    // x - (p >>> FRAC_BITS), saturated to the word
    function automatic t_sat sat_sub(input logic signed [Q_W-1:0] x,
                                     input logic signed [PROD_W-1:0] p);
        logic signed [DIFF_W-1:0] d;
        t_sat                     r;
        d = DIFF_W'(x) - DIFF_W'(p >>> FRAC_BITS);
        if (d > DIFF_W'(Q_MAX)) begin
            r.ovf = 1'b1;
            r.val = Q_MAX;
        end else if (d < DIFF_W'(Q_MIN)) begin
            r.ovf = 1'b1;
            r.val = Q_MIN;
        end else begin
            r.ovf = 1'b0;
            r.val = d[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/tds_if.sv
// row and solution channel interfaces
interface tds_row_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    sub_diag;
    logic signed [31:0]    main_diag;
    logic signed [31:0]    super_diag;
    logic signed [31:0]    rhs_value;
    logic                  last_row;

    modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    input ready);
    modport sink   (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    output ready);
endinterface

interface tds_sol_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    solution_value;
    logic [5:0]            row_index;
    logic                  last_result;
    logic                  solve_error;

    modport source (output valid, solution_value, row_index, last_result, solve_error,
                    input ready);
    modport sink   (input valid, solution_value, row_index, last_result, solve_error,
                    output ready);
endinterface

// File: rtl/core/tds_div.sv
// iterative restoring fixed-point divider, one quotient bit per cycle
module tds_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tds_pkg::t_div_req i_req,
    output tds_pkg::t_div_rsp o_rsp
);
    import tds_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [Q_W:0]       r_rem;
    logic [NUM_W-1:0]   r_quo;
    logic [Q_W-1:0]     r_den;
    logic               r_neg;
    logic               r_done;
    logic               r_err;
    logic [Q_W-1:0]     r_res;

    logic [Q_W:0]       rem_sh;
    logic               fit;
    logic [Q_W-1:0]     num_mag;
    logic [Q_W-1:0]     den_mag;
    logic [NUM_W-1:0]   mag;
    logic [Q_W-1:0]     n_res;
    logic               n_err;

    assign num_mag = i_req.num[Q_W-1] ? Q_W'(-i_req.num) : Q_W'(i_req.num);
    assign den_mag = i_req.den[Q_W-1] ? Q_W'(-i_req.den) : Q_W'(i_req.den);
    assign rem_sh  = {r_rem[Q_W-1:0], r_quo[NUM_W-1]};
    assign fit     = rem_sh >= {1'b0, r_den};
    assign mag     = {r_quo[NUM_W-2:0], fit};

    always_comb begin
        n_err = 1'b0;
        if (r_neg) begin
            if (mag > NUM_W'({1'b1, {(Q_W-1){1'b0}}})) begin
                n_res = Q_MIN;
                n_err = 1'b1;
            end else begin
                n_res = Q_W'(-mag);
            end
        end else begin
            if (mag > NUM_W'(Q_MAX)) begin
                n_res = Q_MAX;
                n_err = 1'b1;
            end else begin
                n_res = mag[Q_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den == '0) begin
                    r_done <= 1'b1;
                    r_err  <= 1'b1;
                    if (i_req.num == '0) begin
                        r_res <= '0;
                    end else if (i_req.num[Q_W-1]) begin
                        r_res <= Q_MIN;
                    end else begin
                        r_res <= Q_MAX;
                    end
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(NUM_W);
                    r_rem  <= '0;
                    r_quo  <= {num_mag, {FRAC_BITS{1'b0}}};
                    r_den  <= den_mag;
                    r_neg  <= i_req.num[Q_W-1] ^ i_req.den[Q_W-1];
                end
            end else if (r_busy) begin
                r_rem <= fit ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_quo <= mag;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_err  <= n_err;
                    r_res  <= n_res;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.err  = r_err;
    assign o_rsp.quo  = r_res;

endmodule

// File: rtl/core/tridiagonal_solver.sv
// tridiagonal solver top level: thomas elimination on a shared divider and multiplier
//
//  channel  dir  beat                                     accept
//  i_row    in   sub/main/super diag, rhs, last_row       valid && ready
//  o_sol    out  solution, row index, last flag, error    valid && ready
//
//  the 48-step divider dominates a row's elimination; a first row skips the division
//  each solution beat waits for a division and then for o_sol.ready
//  i_row.ready is low from a row beat until its elimination ends, and through back substitution
//  synchronous active-low reset clears the sequencer, row count and error flag
//  the three row stores have no reset and are only read where already written
module tridiagonal_solver (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tds_row_if.sink   i_row,
    tds_sol_if.source o_sol
);
    import tds_pkg::*;

    t_state r_state, n_state;

    logic signed [Q_W-1:0] mem_md  [MAX_ROWS];
    logic signed [Q_W-1:0] mem_up  [MAX_ROWS];
    logic signed [Q_W-1:0] mem_rhs [MAX_ROWS];

    logic [IDX_W-1:0]      r_row;
    logic [IDX_W-1:0]      r_r;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_last;
    logic                  r_first;
    logic                  r_err;
    logic signed [Q_W-1:0] r_num;
    logic signed [Q_W-1:0] r_b;
    logic signed [Q_W-1:0] r_f;
    logic signed [Q_W-1:0] r_m;
    logic signed [Q_W-1:0] r_next;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [Q_W-1:0] r_q_md;
    logic signed [Q_W-1:0] r_q_up;
    logic signed [Q_W-1:0] r_q_rhs;

    logic                  accept;
    t_div_req              div_req;
    t_div_rsp              div_rsp;
    logic signed [Q_W-1:0] mul_a;
    logic signed [Q_W-1:0] mul_b;
    logic signed [Q_W-1:0] sub_x;
    t_sat                  sub_r;
    logic                  md_we;
    logic                  rhs_we;
    logic signed [Q_W-1:0] md_wd;
    logic signed [Q_W-1:0] rhs_wd;

    tds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign accept = i_row.valid && i_row.ready;
    assign sub_r  = sat_sub(sub_x, r_prod);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_row.valid) n_state = (r_row == '0) ? S_F_END : S_F_RD;
            S_F_RD:   n_state = S_F_DIV;
            S_F_DIV:  n_state = S_F_DIVW;
            S_F_DIVW: if (div_rsp.done) n_state = S_F_MUL1;
            S_F_MUL1: n_state = S_F_SUB1;
            S_F_SUB1: n_state = S_F_MUL2;
            S_F_MUL2: n_state = S_F_SUB2;
            S_F_SUB2: n_state = S_F_END;
            S_F_END:  n_state = r_last ? S_B_RD : S_IDLE;
            S_B_RD:   n_state = S_B_SEL;
            S_B_SEL:  n_state = r_first ? S_B_DIV : S_B_SUB;
            S_B_SUB:  n_state = S_B_DIV;
            S_B_DIV:  n_state = S_B_DIVW;
            S_B_DIVW: if (div_rsp.done) n_state = S_B_OUT;
            S_B_OUT:  if (o_sol.ready) n_state = (r_r == '0) ? S_IDLE : S_B_RD;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        div_req.start = (r_state == S_F_DIV) || (r_state == S_B_DIV);
        div_req.num   = r_num;
        div_req.den   = r_q_md;
        mul_a  = r_m;
        mul_b  = r_q_up;
        sub_x  = r_b;
        md_we  = 1'b0;
        rhs_we = 1'b0;
        md_wd  = sub_r.val;
        rhs_wd = sub_r.val;
        unique case (r_state)
            S_IDLE: begin
                md_we  = accept && (r_row == '0);
                rhs_we = accept && (r_row == '0);
                md_wd  = i_row.main_diag;
                rhs_wd = i_row.rhs_value;
            end
            S_F_SUB1: md_we = 1'b1;
            S_F_MUL2: mul_b = r_q_rhs;
            S_F_SUB2: begin
                sub_x  = r_f;
                rhs_we = 1'b1;
            end
            S_B_SEL: begin
                mul_a = r_q_up;
                mul_b = r_next;
            end
            S_B_SUB: sub_x = r_q_rhs;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q_md  <= mem_md[r_addr];
        r_q_up  <= mem_up[r_addr];
        r_q_rhs <= mem_rhs[r_addr];
        if (md_we) mem_md[r_row] <= md_wd;
        if (rhs_we) mem_rhs[r_row] <= rhs_wd;
        if (accept) mem_up[r_row] <= i_row.super_diag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_err   <= 1'b0;
            r_next  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_addr <= r_row - 1'b1;
                    r_num  <= i_row.sub_diag;
                    r_b    <= i_row.main_diag;
                    r_f    <= i_row.rhs_value;
                    r_last <= i_row.last_row || (r_row == IDX_W'(MAX_ROWS - 1));
                end
                S_F_DIVW: if (div_rsp.done) begin
                    r_m   <= div_rsp.quo;
                    r_err <= r_err | div_rsp.err;
                end
                S_F_MUL1, S_F_MUL2, S_B_SEL: r_prod <= mul_a * mul_b;
                S_F_SUB1, S_F_SUB2: r_err <= r_err | sub_r.ovf;
                S_F_END: begin
                    if (r_last) begin
                        r_r     <= r_row;
                        r_addr  <= r_row;
                        r_first <= 1'b1;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_B_SUB: begin
                    r_num <= sub_r.val;
                    r_err <= r_err | sub_r.ovf;
                end
                S_B_DIVW: if (div_rsp.done) begin
                    r_next <= div_rsp.quo;
                    r_err  <= r_err | div_rsp.err;
                end
                S_B_OUT: if (o_sol.ready) begin
                    r_first <= 1'b0;
                    if (r_r == '0) begin
                        r_row <= '0;
                        r_err <= 1'b0;
                    end else begin
                        r_r    <= r_r - 1'b1;
                        r_addr <= r_r - 1'b1;
                    end
                end
                default: ;
            endcase
            if (r_state == S_B_SEL && r_first) r_num <= r_q_rhs;
        end
    end

    assign i_row.ready          = (r_state == S_IDLE);
    assign o_sol.valid          = (r_state == S_B_OUT);
    assign o_sol.solution_value = r_next;
    assign o_sol.row_index      = 6'(r_r);
    assign o_sol.last_result    = (r_r == '0);
    assign o_sol.solve_error    = r_err;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_row.ready && o_sol.valid))
        else $error("row and solution channels open together");

    a_busy_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_row != '0) |=> !i_row.ready)
        else $error("ready during elimination");

    a_div_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_F_DIVW || r_state == S_B_DIVW))
        else $error("divider finished outside a wait state");

    a_last_is_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sol.valid && o_sol.ready && o_sol.last_result) |=> (r_row == '0 && !r_err))
        else $error("solve state not cleared after last beat");

endmodule

// File: test/tds_scoreboard.sv
// scoreboard for the tridiagonal solver: fixed-point thomas predictor and result check
`timescale 1ns / 1ps
class tds_scoreboard;
    typedef struct {
        logic signed [31:0] value;
        logic [5:0]         index;
        logic               last;
        logic               err;
    } t_solution;

    localparam int ROWS = tds_pkg::MAX_ROWS;
    localparam int FB   = tds_pkg::FRAC_BITS;

    logic signed [31:0] pivot_diag[ROWS];
    logic signed [31:0] upper_coef[ROWS];
    logic signed [31:0] elim_rhs[ROWS];
    int                 rows_taken;
    logic signed [31:0] prev_x;
    bit                 overflow_seen;
    t_solution          pending[$];
    int                 mismatches;
    int                 solves_done;

    function new();
        rows_taken = 0;
        prev_x = 0;
        overflow_seen = 0;
        mismatches = 0;
        solves_done = 0;
    endfunction

    function logic signed [31:0] clip(longint v);
        if (v > longint'(tds_pkg::Q_MAX)) begin
            overflow_seen = 1;
            return tds_pkg::Q_MAX;
        end
        if (v < longint'(tds_pkg::Q_MIN)) begin
            overflow_seen = 1;
            return tds_pkg::Q_MIN;
        end
        return v[31:0];
    endfunction

    // product scaled down, floor rounding
    function longint q_mul(logic signed [31:0] x, logic signed [31:0] y);
        longint p;
        p = longint'(x) * longint'(y);
        return p >>> FB;
    endfunction

    function logic signed [31:0] q_div(logic signed [31:0] num, logic signed [31:0] den);
        longint n;
        if (den == 0) begin
            overflow_seen = 1;
            if (num > 0) return tds_pkg::Q_MAX;
            if (num < 0) return tds_pkg::Q_MIN;
            return 0;
        end
        n = longint'(num) * (longint'(1) << FB);
        return clip(n / longint'(den));
    endfunction

    function void note_row(logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] f, logic last);
        int                 i;
        int                 n;
        logic signed [31:0] m;
        logic signed [31:0] num;
        t_solution          s;
        i = rows_taken;
        if (i >= ROWS) begin
            i = ROWS - 1;
            last = 1;
        end
        if (i == 0) begin
            pivot_diag[0] = b;
            elim_rhs[0] = f;
        end else begin
            m = q_div(a, pivot_diag[i-1]);
            pivot_diag[i] = clip(longint'(b) - q_mul(m, upper_coef[i-1]));
            elim_rhs[i] = clip(longint'(f) - q_mul(m, elim_rhs[i-1]));
        end
        upper_coef[i] = c;
        if (i == ROWS - 1) last = 1;
        if (!last) begin
            rows_taken = i + 1;
            return;
        end
        n = i + 1;
        for (int r = n - 1; r >= 0; r--) begin
            if (r == n - 1) begin
                s.value = q_div(elim_rhs[r], pivot_diag[r]);
            end else begin
                num = clip(longint'(elim_rhs[r]) - q_mul(upper_coef[r], prev_x));
                s.value = q_div(num, pivot_diag[r]);
            end
            prev_x = s.value;
            s.index = r[5:0];
            s.last = (r == 0);
            s.err = overflow_seen;
            pending.push_back(s);
        end
        rows_taken = 0;
        overflow_seen = 0;
    endfunction

    function void check_solution(logic signed [31:0] value, logic [5:0] index,
                                 logic last, logic err);
        t_solution s;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected solution beat: x=%0d row=%0d", value, index);
            return;
        end
        s = pending.pop_front();
        if (last) solves_done++;
        if (s.value !== value || s.index !== index || s.last !== last || s.err !== err) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%0d row=%0d last=%0b err=%0b, got x=%0d row=%0d last=%0b err=%0b",
                         s.value, s.index, s.last, s.err, value, index, last, err);
        end
    endfunction
endclass

// File: test/testbench.sv
// testbench top: drives rows into the tridiagonal solver and checks solution beats
`timescale 1ns / 1ps
module testbench;
    logic i_clk = 0;
    logic i_rst_n = 0;
    bit   rows_done = 0;
    int   rows_sent = 0;
    int   sol_hold = 0;

    tds_row_if row_ch();
    tds_sol_if sol_ch();

    tridiagonal_solver DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_row  (row_ch.sink),
        .o_sol  (sol_ch.source)
    );

    tds_scoreboard board = new();

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom();
            default: return $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_pivot();
        logic [31:0] v;
        v = $urandom_range(32'h2_0000, 32'h10_0000);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    task automatic send_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] f, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            row_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        row_ch.valid <= 1;
        row_ch.sub_diag <= a;
        row_ch.main_diag <= b;
        row_ch.super_diag <= c;
        row_ch.rhs_value <= f;
        row_ch.last_row <= last;
        do @(posedge i_clk); while (!row_ch.ready);
        board.note_row(a, b, c, f, last);
        rows_sent++;
    endtask

    task automatic send_system(int n, bit dominant);
        for (int k = 0; k < n; k++) begin
            if (dominant)
                send_row(rand_word() >>> 2, rand_pivot(), rand_word() >>> 2,
                         rand_word(), k == n - 1);
            else
                send_row(rand_word(), rand_word(), rand_word(), rand_word(), k == n - 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && sol_ch.valid && sol_ch.ready)
            board.check_solution(sol_ch.solution_value, sol_ch.row_index,
                                 sol_ch.last_result, sol_ch.solve_error);
        if (!i_rst_n) begin
            sol_ch.ready <= 0;
            sol_hold <= 0;
        end else if (sol_hold > 0) begin
            sol_ch.ready <= 0;
            sol_hold <= sol_hold - 1;
        end else if ($urandom_range(0, 99) < 3) begin
            sol_ch.ready <= 0;
            sol_hold <= $urandom_range(10, 60);
        end else begin
            sol_ch.ready <= ($urandom_range(0, 99) < 85);
        end
    end

    initial begin
        row_ch.valid = 0;
        row_ch.sub_diag = 0;
        row_ch.main_diag = 0;
        row_ch.super_diag = 0;
        row_ch.rhs_value = 0;
        row_ch.last_row = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // single rows, zero pivot cases, extremes
        send_row(32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000, 32'h0003_0000, 1);
        send_row(0, 0, 0, 32'h0001_0000, 1);
        send_row(0, 0, 0, 32'hffff_0000, 1);
        send_row(0, 0, 0, 0, 1);
        send_row(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 1);
        send_row(0, 32'hffff_ffff, 0, 32'h8000_0000, 1);
        // two rows with a zero pivot in the first row
        send_row(0, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_row(32'h0001_0000, 32'h0002_0000, 0, 32'h0002_0000, 1);
        // saturating sub-diagonal
        send_row(0, 32'h0000_0100, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        send_row(32'hffff_ffff, 32'h0002_0000, 32'hffff_ffff, 32'h0001_0000, 0);
        send_row(32'h0000_8000, 32'h0004_0000, 32'h0001_0000, 32'hffff_ffff, 0);
        send_row(32'h0000_8000, 32'h0003_0000, 32'h0000_0000, 32'h0005_0000, 1);
        // overlong system: row at the top index ends it without the flag
        for (int k = 0; k < tds_pkg::MAX_ROWS; k++)
            send_row(32'h0000_4000, 32'h0004_0000, 32'h0000_4000, k << 12, 0);
        // random systems, mostly well conditioned, small sizes
        while (rows_sent < 380) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 3) send_system(tds_pkg::MAX_ROWS, 1);
            else if (r < 75) send_system($urandom_range(1, 6), 1);
            else send_system($urandom_range(1, 4), 0);
        end
        row_ch.valid <= 0;
        rows_done = 1;
    end

    initial begin
        wait (rows_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
